[sv/lkv_pkg.sv]
`default_nettype none

package lkv_pkg;

   // Default number of fraction bits of the Q format.
   localparam int FRAC_BITS_DEF = 16;

   // Fixed data widths.
   localparam int DATA_W    = 32;
   localparam int DIFF_W    = 33;
   localparam int NRM_W     = 30;
   localparam int NRM_TOP   = 29;
   localparam int LEAD_W    = 6;
   localparam int SQ_W      = 60;
   localparam int SUM_W     = 62;
   localparam int ROOT_W    = 31;
   localparam int ISQ_REM_W = 34;
   localparam int DIV_REM_W = 33;
   localparam int PROD_W    = 64;

   // Square root: one result bit per step, a few steps per pipeline stage.
   localparam int ISQ_STEPS  = 31;
   localparam int ISQ_PER    = 4;
   localparam int ISQ_STAGES = (ISQ_STEPS + ISQ_PER - 1) / ISQ_PER;

   // Divider: quotient bits per pipeline stage.
   localparam int DIV_PER = 4;

   // Output word numbering.
   typedef logic [1:0] word_type;
   localparam word_type WORD_LAST = 2'd3;

   // Saturation bounds.
   localparam logic signed [PROD_W-1:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT_LO = -64'sd2147483648;

   // State of the digit-by-digit square root.
   typedef struct packed {
      logic [ISQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0]    root;
      logic [SUM_W-1:0]     rad;
   } isq_type;

   // One restoring division step result.
   typedef struct packed {
      logic [DIV_REM_W-1:0] rem;
      logic                 qb;
   } div_type;

   // Status that travels with the result of a normalize unit.
   typedef struct packed {
      logic valid;
      logic zero;
   } nrm_stat_type;

   // One square root step: brings in the next two radicand bits.
   function automatic isq_type isq_step(input isq_type s);
      isq_type              o;
      logic [ISQ_REM_W-1:0] acc;
      logic [ISQ_REM_W-1:0] trial;
      acc   = {s.rem[ISQ_REM_W-3:0], s.rad[SUM_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      o.rad = {s.rad[SUM_W-3:0], 2'b00};
      if (acc >= trial) begin
         o.rem  = acc - trial;
         o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem  = acc;
         o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // One restoring division step: shift in a bit, subtract if it fits.
   function automatic div_type div_step(input logic [DIV_REM_W-1:0] rem,
                                        input logic [ROOT_W-1:0] d,
                                        input logic b);
      div_type              o;
      logic [DIV_REM_W-1:0] acc;
      logic [DIV_REM_W-1:0] dx;
      acc = {rem[DIV_REM_W-2:0], b};
      dx  = {2'b00, d};
      if (acc >= dx) begin
         o.rem = acc - dx;
         o.qb  = 1'b1;
      end else begin
         o.rem = acc;
         o.qb  = 1'b0;
      end
      return o;
   endfunction

   // Clamp a wide signed value to the 32-bit range.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] o;
      if (v > SAT_HI) begin
         o = 32'sh7fffffff;
      end else if (v < SAT_LO) begin
         o = 32'sh80000000;
      end else begin
         o = v[DATA_W-1:0];
      end
      return o;
   endfunction

endpackage

`default_nettype wire

[sv/lkv_norm.sv]
`default_nettype none

// Pipelined vector normalize: range shift, squares, sum, square root, divide.
module lkv_norm #(
   parameter int FRAC_BITS = lkv_pkg::FRAC_BITS_DEF,
   parameter int SIDE_W    = 1
) (
   input  wire  logic                                   clock,
   input  wire  logic                                   reset,
   input  wire  logic                                   en,
   input  wire  logic                                   in_valid,
   input  wire  logic [2:0][lkv_pkg::DIFF_W-1:0]        in_vec,
   input  wire  logic [SIDE_W-1:0]                      in_side,
   output lkv_pkg::nrm_stat_type                        out_stat,
   output logic [2:0][lkv_pkg::DATA_W-1:0]              out_vec,
   output logic [SIDE_W-1:0]                            out_side
);

   localparam int DW      = lkv_pkg::DATA_W;
   localparam int XW      = lkv_pkg::DIFF_W;
   localparam int NW      = lkv_pkg::NRM_W;
   localparam int LW      = lkv_pkg::LEAD_W;
   localparam int SQW     = lkv_pkg::SQ_W;
   localparam int SUMW    = lkv_pkg::SUM_W;
   localparam int RW      = lkv_pkg::ROOT_W;
   localparam int DRW     = lkv_pkg::DIV_REM_W;
   localparam int ISQ_N   = lkv_pkg::ISQ_STAGES;
   localparam int QW      = FRAC_BITS + 1;
   localparam int DIV_N   = (QW + lkv_pkg::DIV_PER - 1) / lkv_pkg::DIV_PER;

   // Range shift stage.
   logic [2:0][XW-1:0]   a_mag;
   logic [XW-1:0]        a_big;
   logic [LW-1:0]        a_lead;
   logic [2:0][NW-1:0]   a_sm_in;
   logic                 a_zero_in;
   logic                 a_v_ff;
   logic [2:0][NW-1:0]   a_sm_ff;
   logic [2:0]           a_neg_ff;
   logic                 a_zero_ff;
   logic [SIDE_W-1:0]    a_side_ff;

   // Squares and sum stages.
   logic                 b_v_ff;
   logic [2:0][SQW-1:0]  b_sq_ff;
   logic [2:0][NW-1:0]   b_sm_ff;
   logic [2:0]           b_neg_ff;
   logic                 b_zero_ff;
   logic [SIDE_W-1:0]    b_side_ff;
   logic                 c_v_ff;
   logic [SUMW-1:0]      c_sum_ff;
   logic [2:0][NW-1:0]   c_sm_ff;
   logic [2:0]           c_neg_ff;
   logic                 c_zero_ff;
   logic [SIDE_W-1:0]    c_side_ff;

   // Square root stages.
   lkv_pkg::isq_type     isq_in   [ISQ_N];
   lkv_pkg::isq_type     isq_ff   [ISQ_N];
   logic                 isq_v_ff [ISQ_N];
   logic [2:0][NW-1:0]   isq_sm_ff [ISQ_N];
   logic [2:0]           isq_neg_ff [ISQ_N];
   logic                 isq_zero_ff [ISQ_N];
   logic [SIDE_W-1:0]    isq_side_ff [ISQ_N];

   // Divider stages, three lanes sharing one divisor.
   logic [2:0][DRW-1:0]  div_rem_in [DIV_N];
   logic [2:0][QW-1:0]   div_q_in   [DIV_N];
   logic [2:0][DRW-1:0]  div_rem_ff [DIV_N];
   logic [2:0][QW-1:0]   div_q_ff   [DIV_N];
   logic [RW-1:0]        div_d_ff   [DIV_N];
   logic                 div_v_ff   [DIV_N];
   logic [2:0]           div_neg_ff [DIV_N];
   logic                 div_zero_ff [DIV_N];
   logic [SIDE_W-1:0]    div_side_ff [DIV_N];

   // Output stage.
   logic [2:0][DW-1:0]   o_vec_in;
   logic                 o_v_ff;
   logic                 o_zero_ff;
   logic [2:0][DW-1:0]   o_vec_ff;
   logic [SIDE_W-1:0]    o_side_ff;

   // Magnitudes, largest one and the shift that puts it in the normal range.
   always_comb begin
      a_big  = '0;
      a_lead = '0;
      for (int i = 0; i < 3; i++) begin
         a_mag[i] = in_vec[i][XW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
         if (a_mag[i] > a_big) begin
            a_big = a_mag[i];
         end
      end
      for (int b = 0; b < XW; b++) begin
         if (a_big[b]) begin
            a_lead = LW'(b);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (a_lead > LW'(lkv_pkg::NRM_TOP)) begin
            a_sm_in[i] = NW'(a_mag[i] >> (a_lead - LW'(lkv_pkg::NRM_TOP)));
         end else begin
            a_sm_in[i] = NW'(a_mag[i] << (LW'(lkv_pkg::NRM_TOP) - a_lead));
         end
      end
      a_zero_in = (a_big == '0);
   end

   // Square root steps, a fixed group of them per stage.
   always_comb begin
      lkv_pkg::isq_type t;
      t.rem  = '0;
      t.root = '0;
      t.rad  = c_sum_ff;
      for (int s = 0; s < ISQ_N; s++) begin
         if (s > 0) begin
            t = isq_ff[s-1];
         end
         for (int k = 0; k < lkv_pkg::ISQ_PER; k++) begin
            if (s * lkv_pkg::ISQ_PER + k < lkv_pkg::ISQ_STEPS) begin
               t = lkv_pkg::isq_step(t);
            end
         end
         isq_in[s] = t;
      end
   end

   // Division steps: quotient bits from the top down, the first step takes
   // the low bit of the magnitude, the rest shift in zeros.
   always_comb begin
      logic [2:0][DRW-1:0] r;
      logic [2:0][QW-1:0]  q;
      logic [RW-1:0]       d;
      lkv_pkg::div_type    st;
      for (int s = 0; s < DIV_N; s++) begin
         if (s == 0) begin
            d = isq_ff[ISQ_N-1].root;
            for (int i = 0; i < 3; i++) begin
               r[i] = DRW'(isq_sm_ff[ISQ_N-1][i] >> 1);
               q[i] = '0;
            end
         end else begin
            d = div_d_ff[s-1];
            r = div_rem_ff[s-1];
            q = div_q_ff[s-1];
         end
         for (int k = 0; k < lkv_pkg::DIV_PER; k++) begin
            if (s * lkv_pkg::DIV_PER + k < QW) begin
               for (int i = 0; i < 3; i++) begin
                  st   = lkv_pkg::div_step(r[i], d,
                            (s * lkv_pkg::DIV_PER + k == 0) ?
                            isq_sm_ff[ISQ_N-1][i][0] : 1'b0);
                  r[i] = st.rem;
                  q[i] = {q[i][QW-2:0], st.qb};
               end
            end
         end
         div_rem_in[s] = r;
         div_q_in[s]   = q;
      end
   end

   // Apply the signs; a zero vector gives zero.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (div_zero_ff[DIV_N-1]) begin
            o_vec_in[i] = '0;
         end else if (div_neg_ff[DIV_N-1][i]) begin
            o_vec_in[i] = ~DW'(div_q_ff[DIV_N-1][i]) + 1'b1;
         end else begin
            o_vec_in[i] = DW'(div_q_ff[DIV_N-1][i]);
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         for (int s = 0; s < ISQ_N; s++) begin
            isq_v_ff[s] <= 1'b0;
         end
         for (int s = 0; s < DIV_N; s++) begin
            div_v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         a_v_ff      <= in_valid;
         b_v_ff      <= a_v_ff;
         c_v_ff      <= b_v_ff;
         isq_v_ff[0] <= c_v_ff;
         for (int s = 1; s < ISQ_N; s++) begin
            isq_v_ff[s] <= isq_v_ff[s-1];
         end
         div_v_ff[0] <= isq_v_ff[ISQ_N-1];
         for (int s = 1; s < DIV_N; s++) begin
            div_v_ff[s] <= div_v_ff[s-1];
         end
         o_v_ff <= div_v_ff[DIV_N-1];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         a_sm_ff   <= a_sm_in;
         a_zero_ff <= a_zero_in;
         for (int i = 0; i < 3; i++) begin
            a_neg_ff[i] <= in_vec[i][XW-1];
            b_sq_ff[i]  <= SQW'(a_sm_ff[i]) * SQW'(a_sm_ff[i]);
         end
         a_side_ff <= in_side;

         b_sm_ff   <= a_sm_ff;
         b_neg_ff  <= a_neg_ff;
         b_zero_ff <= a_zero_ff;
         b_side_ff <= a_side_ff;

         c_sum_ff  <= SUMW'(b_sq_ff[0]) + SUMW'(b_sq_ff[1]) + SUMW'(b_sq_ff[2]);
         c_sm_ff   <= b_sm_ff;
         c_neg_ff  <= b_neg_ff;
         c_zero_ff <= b_zero_ff;
         c_side_ff <= b_side_ff;

         for (int s = 0; s < ISQ_N; s++) begin
            isq_ff[s] <= isq_in[s];
         end
         isq_sm_ff[0]   <= c_sm_ff;
         isq_neg_ff[0]  <= c_neg_ff;
         isq_zero_ff[0] <= c_zero_ff;
         isq_side_ff[0] <= c_side_ff;
         for (int s = 1; s < ISQ_N; s++) begin
            isq_sm_ff[s]   <= isq_sm_ff[s-1];
            isq_neg_ff[s]  <= isq_neg_ff[s-1];
            isq_zero_ff[s] <= isq_zero_ff[s-1];
            isq_side_ff[s] <= isq_side_ff[s-1];
         end

         for (int s = 0; s < DIV_N; s++) begin
            div_rem_ff[s] <= div_rem_in[s];
            div_q_ff[s]   <= div_q_in[s];
         end
         div_d_ff[0]    <= isq_ff[ISQ_N-1].root;
         div_neg_ff[0]  <= isq_neg_ff[ISQ_N-1];
         div_zero_ff[0] <= isq_zero_ff[ISQ_N-1];
         div_side_ff[0] <= isq_side_ff[ISQ_N-1];
         for (int s = 1; s < DIV_N; s++) begin
            div_d_ff[s]    <= div_d_ff[s-1];
            div_neg_ff[s]  <= div_neg_ff[s-1];
            div_zero_ff[s] <= div_zero_ff[s-1];
            div_side_ff[s] <= div_side_ff[s-1];
         end

         o_vec_ff  <= o_vec_in;
         o_zero_ff <= div_zero_ff[DIV_N-1];
         o_side_ff <= div_side_ff[DIV_N-1];
      end
   end

   assign out_stat.valid = o_v_ff;
   assign out_stat.zero  = o_zero_ff;
   assign out_vec        = o_vec_ff;
   assign out_side       = o_side_ff;

endmodule

`default_nettype wire

[sv/look_at_view_matrix.sv]
// Look-at view matrix builder.
// Request channel (req_valid/req_ready) takes one transaction per camera
// update: position and target, signed Q format with FRAC_BITS fraction bits.
// Response channel (rsp_valid/rsp_ready) returns four transactions per
// request, word_index 0 to 3, one column of the matrix each; rsp_last marks
// the fourth. rsp_degenerate is the same on all four words.
// From request to the first word the path runs through two normalize units
// with a 31-step square root and a (FRAC_BITS+1)-step divider, four steps per
// stage, then four product and sum stages.
// The output register sends four response words per request; the pipeline
// holds many requests at once.
// The finished matrix sits in an output register. While its words are being
// sent, or while the receiver holds rsp_ready low, the whole pipeline holds;
// a new request is taken in the cycle the last word goes out.
// Synchronous reset empties the pipeline and the word counter.
`default_nettype none

module look_at_view_matrix #(
   parameter int FRAC_BITS = lkv_pkg::FRAC_BITS_DEF
) (
   input  wire  logic                        clock,
   input  wire  logic                        reset,
   input  wire  logic                        req_valid,
   output logic                              req_ready,
   input  wire  logic signed [31:0]          req_pos_x,
   input  wire  logic signed [31:0]          req_pos_y,
   input  wire  logic signed [31:0]          req_pos_z,
   input  wire  logic signed [31:0]          req_target_x,
   input  wire  logic signed [31:0]          req_target_y,
   input  wire  logic signed [31:0]          req_target_z,
   output logic                              rsp_valid,
   input  wire  logic                        rsp_ready,
   output logic [1:0]                        rsp_word_index,
   output logic signed [31:0]                rsp_elem0,
   output logic signed [31:0]                rsp_elem1,
   output logic signed [31:0]                rsp_elem2,
   output logic signed [31:0]                rsp_elem3,
   output logic                              rsp_degenerate,
   output logic                              rsp_last
);

   localparam int DW = lkv_pkg::DATA_W;
   localparam int XW = lkv_pkg::DIFF_W;
   localparam int PW = lkv_pkg::PROD_W;
   localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

   typedef logic [2:0][DW-1:0] vec_type;

   typedef struct packed {
      logic    degen;
      vec_type f;
      vec_type p;
   } side2_type;

   // Magnitude of a 32-bit signed value.
   function automatic logic [DW-1:0] mag32(input logic [DW-1:0] v);
      return v[DW-1] ? (~v + 1'b1) : v;
   endfunction

   // Truncated product term with its sign applied.
   function automatic logic signed [PW-1:0] qterm(input logic [PW-1:0] m, input logic neg);
      logic [PW-1:0] sh;
      sh = m >> FRAC_BITS;
      return neg ? -$signed(sh) : $signed(sh);
   endfunction

   logic                 en;
   lkv_pkg::word_type    cnt_ff;

   // Input stage.
   logic                 t0_v_ff;
   vec_type              t0_p_ff;
   logic [2:0][XW-1:0]   t0_d_ff;

   // Forward normalize.
   lkv_pkg::nrm_stat_type n1_stat;
   vec_type              n1_vec;
   vec_type              n1_side;

   // Right vector seed.
   logic                 h_v_ff;
   logic [2:0][XW-1:0]   h_vec_ff;
   side2_type            h_side_ff;

   // Right normalize.
   lkv_pkg::nrm_stat_type n2_stat;
   vec_type              n2_vec;
   side2_type            n2_side;

   // Product stage.
   logic                 s1_v_ff;
   logic [5:0][PW-1:0]   s1_pu_ff;
   logic [5:0]           s1_pun_ff;
   logic [2:0][PW-1:0]   s1_rp_ff;
   logic [2:0]           s1_rpn_ff;
   logic [2:0][PW-1:0]   s1_fp_ff;
   logic [2:0]           s1_fpn_ff;
   vec_type              s1_r_ff;
   vec_type              s1_f_ff;
   vec_type              s1_p_ff;
   logic                 s1_degen_ff;

   // Cross product and first dot products.
   logic [2:0][XW-1:0]   s2_u_in;
   logic [DW-1:0]        s2_nrp_in;
   logic [DW-1:0]        s2_nfp_in;
   logic                 s2_v_ff;
   logic [2:0][XW-1:0]   s2_u_ff;
   logic [DW-1:0]        s2_nrp_ff;
   logic [DW-1:0]        s2_nfp_ff;
   vec_type              s2_r_ff;
   vec_type              s2_f_ff;
   vec_type              s2_p_ff;
   logic                 s2_degen_ff;

   // Up-vector dot products.
   logic [2:0][PW-1:0]   s3_up_in;
   logic [2:0]           s3_upn_in;
   logic                 s3_v_ff;
   logic [2:0][PW-1:0]   s3_up_ff;
   logic [2:0]           s3_upn_ff;
   logic [2:0][XW-1:0]   s3_u_ff;
   logic [DW-1:0]        s3_nrp_ff;
   logic [DW-1:0]        s3_nfp_ff;
   vec_type              s3_r_ff;
   vec_type              s3_f_ff;
   logic                 s3_degen_ff;

   // Finished matrix, held while its four words go out.
   logic [DW-1:0]        rec_nup_in;
   logic                 rec_v_ff;
   vec_type              rec_r_ff;
   vec_type              rec_u_ff;
   vec_type              rec_f_ff;
   logic [DW-1:0]        rec_nrp_ff;
   logic [DW-1:0]        rec_nup_ff;
   logic [DW-1:0]        rec_nfp_ff;
   logic                 rec_degen_ff;

   // The pipeline moves when the output register is empty or frees now.
   assign en        = !rec_v_ff || (rsp_ready && (cnt_ff == lkv_pkg::WORD_LAST));
   assign req_ready = en;

   lkv_norm #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(vec_type))
   ) u_norm_fwd (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (t0_v_ff),
      .in_vec   (t0_d_ff),
      .in_side  (t0_p_ff),
      .out_stat (n1_stat),
      .out_vec  (n1_vec),
      .out_side (n1_side)
   );

   lkv_norm #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(side2_type))
   ) u_norm_right (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (h_v_ff),
      .in_vec   (h_vec_ff),
      .in_side  (h_side_ff),
      .out_stat (n2_stat),
      .out_vec  (n2_vec),
      .out_side (n2_side)
   );

   // Cross product terms and first dot product sums.
   always_comb begin
      logic signed [PW-1:0] du [3];
      logic signed [PW-1:0] rsum;
      logic signed [PW-1:0] fsum;
      for (int i = 0; i < 3; i++) begin
         du[i] = qterm(s1_pu_ff[2*i], s1_pun_ff[2*i]) -
                 qterm(s1_pu_ff[2*i+1], s1_pun_ff[2*i+1]);
         s2_u_in[i] = du[i][XW-1:0];
      end
      rsum = qterm(s1_rp_ff[0], s1_rpn_ff[0]) + qterm(s1_rp_ff[1], s1_rpn_ff[1]) +
             qterm(s1_rp_ff[2], s1_rpn_ff[2]);
      fsum = qterm(s1_fp_ff[0], s1_fpn_ff[0]) + qterm(s1_fp_ff[1], s1_fpn_ff[1]) +
             qterm(s1_fp_ff[2], s1_fpn_ff[2]);
      s2_nrp_in = lkv_pkg::sat32(-rsum);
      s2_nfp_in = lkv_pkg::sat32(-fsum);
   end

   // Products of the up vector with the position.
   always_comb begin
      logic [XW-1:0] um;
      for (int i = 0; i < 3; i++) begin
         um           = s2_u_ff[i][XW-1] ? (~s2_u_ff[i] + 1'b1) : s2_u_ff[i];
         s3_up_in[i]  = PW'(um[DW-1:0]) * PW'(mag32(s2_p_ff[i]));
         s3_upn_in[i] = s2_u_ff[i][XW-1] ^ s2_p_ff[i][DW-1];
      end
   end

   // Last dot product sum.
   always_comb begin
      logic signed [PW-1:0] usum;
      usum = qterm(s3_up_ff[0], s3_upn_ff[0]) + qterm(s3_up_ff[1], s3_upn_ff[1]) +
             qterm(s3_up_ff[2], s3_upn_ff[2]);
      rec_nup_in = lkv_pkg::sat32(-usum);
   end

   // Valid bits of the top-level stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         t0_v_ff  <= 1'b0;
         h_v_ff   <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rec_v_ff <= 1'b0;
      end else if (en) begin
         t0_v_ff  <= req_valid;
         h_v_ff   <= n1_stat.valid;
         s1_v_ff  <= n2_stat.valid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         rec_v_ff <= s3_v_ff;
      end
   end

   // Word counter of the response transaction in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   // Payload registers of the top-level stages.
   always_ff @(posedge clock) begin
      if (en) begin
         t0_p_ff    <= {req_pos_z, req_pos_y, req_pos_x};
         t0_d_ff[0] <= XW'(req_pos_x) - XW'(req_target_x);
         t0_d_ff[1] <= XW'(req_pos_y) - XW'(req_target_y);
         t0_d_ff[2] <= XW'(req_pos_z) - XW'(req_target_z);

         h_vec_ff[0]     <= XW'($signed(n1_vec[2]));
         h_vec_ff[1]     <= '0;
         h_vec_ff[2]     <= ~XW'($signed(n1_vec[0])) + 1'b1;
         h_side_ff.degen <= n1_stat.zero;
         h_side_ff.f     <= n1_vec;
         h_side_ff.p     <= n1_side;

         s1_pu_ff[0]  <= PW'(mag32(n2_side.f[1])) * PW'(mag32(n2_vec[2]));
         s1_pu_ff[1]  <= PW'(mag32(n2_side.f[2])) * PW'(mag32(n2_vec[1]));
         s1_pu_ff[2]  <= PW'(mag32(n2_side.f[2])) * PW'(mag32(n2_vec[0]));
         s1_pu_ff[3]  <= PW'(mag32(n2_side.f[0])) * PW'(mag32(n2_vec[2]));
         s1_pu_ff[4]  <= PW'(mag32(n2_side.f[0])) * PW'(mag32(n2_vec[1]));
         s1_pu_ff[5]  <= PW'(mag32(n2_side.f[1])) * PW'(mag32(n2_vec[0]));
         s1_pun_ff[0] <= n2_side.f[1][DW-1] ^ n2_vec[2][DW-1];
         s1_pun_ff[1] <= n2_side.f[2][DW-1] ^ n2_vec[1][DW-1];
         s1_pun_ff[2] <= n2_side.f[2][DW-1] ^ n2_vec[0][DW-1];
         s1_pun_ff[3] <= n2_side.f[0][DW-1] ^ n2_vec[2][DW-1];
         s1_pun_ff[4] <= n2_side.f[0][DW-1] ^ n2_vec[1][DW-1];
         s1_pun_ff[5] <= n2_side.f[1][DW-1] ^ n2_vec[0][DW-1];
         for (int i = 0; i < 3; i++) begin
            s1_rp_ff[i]  <= PW'(mag32(n2_vec[i])) * PW'(mag32(n2_side.p[i]));
            s1_rpn_ff[i] <= n2_vec[i][DW-1] ^ n2_side.p[i][DW-1];
            s1_fp_ff[i]  <= PW'(mag32(n2_side.f[i])) * PW'(mag32(n2_side.p[i]));
            s1_fpn_ff[i] <= n2_side.f[i][DW-1] ^ n2_side.p[i][DW-1];
         end
         s1_r_ff     <= n2_vec;
         s1_f_ff     <= n2_side.f;
         s1_p_ff     <= n2_side.p;
         s1_degen_ff <= n2_side.degen | n2_stat.zero;

         s2_u_ff     <= s2_u_in;
         s2_nrp_ff   <= s2_nrp_in;
         s2_nfp_ff   <= s2_nfp_in;
         s2_r_ff     <= s1_r_ff;
         s2_f_ff     <= s1_f_ff;
         s2_p_ff     <= s1_p_ff;
         s2_degen_ff <= s1_degen_ff;

         s3_up_ff    <= s3_up_in;
         s3_upn_ff   <= s3_upn_in;
         s3_u_ff     <= s2_u_ff;
         s3_nrp_ff   <= s2_nrp_ff;
         s3_nfp_ff   <= s2_nfp_ff;
         s3_r_ff     <= s2_r_ff;
         s3_f_ff     <= s2_f_ff;
         s3_degen_ff <= s2_degen_ff;

         for (int i = 0; i < 3; i++) begin
            rec_u_ff[i] <= lkv_pkg::sat32(PW'($signed(s3_u_ff[i])));
         end
         rec_r_ff     <= s3_r_ff;
         rec_f_ff     <= s3_f_ff;
         rec_nrp_ff   <= s3_nrp_ff;
         rec_nup_ff   <= rec_nup_in;
         rec_nfp_ff   <= s3_nfp_ff;
         rec_degen_ff <= s3_degen_ff;
      end
   end

   // Word selection: columns of the rotation, then the translation word.
   always_comb begin
      case (cnt_ff)
         lkv_pkg::WORD_LAST: begin
            rsp_elem0 = rec_nrp_ff;
            rsp_elem1 = rec_nup_ff;
            rsp_elem2 = rec_nfp_ff;
            rsp_elem3 = ONE_Q;
         end
         default: begin
            rsp_elem0 = rec_r_ff[cnt_ff];
            rsp_elem1 = rec_u_ff[cnt_ff];
            rsp_elem2 = rec_f_ff[cnt_ff];
            rsp_elem3 = '0;
         end
      endcase
   end

   assign rsp_valid      = rec_v_ff;
   assign rsp_word_index = cnt_ff;
   assign rsp_degenerate = rec_degen_ff;
   assign rsp_last       = (cnt_ff == lkv_pkg::WORD_LAST);

   // The word counter only runs while a matrix is held.
   a_cnt_held: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd0 |-> rec_v_ff)
      else $error("word counter moved without a held matrix");

   // A new request is only taken when the held matrix is empty or finishing.
   a_take_on_last: assert property (@(posedge clock) disable iff (reset)
      rec_v_ff && req_ready |-> cnt_ff == lkv_pkg::WORD_LAST && rsp_ready)
      else $error("request taken while a matrix is mid-transfer");

   // Inside one matrix the degenerate flag does not change.
   a_degen_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && $stable(rsp_degenerate))
      else $error("degenerate flag changed within a matrix");

   // A degenerate matrix has zero right and up vectors.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate && !rsp_last |-> rsp_elem0 == '0 && rsp_elem1 == '0)
      else $error("degenerate matrix with nonzero right or up vector");

   // The translation word carries one in the last element.
   a_last_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_elem3 == ONE_Q)
      else $error("last word without unit element");

endmodule

`default_nettype wire

[tb/look_at_view_matrix_tb.sv]
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

   localparam int FRAC = lkv_pkg::FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [31:0] ONE_Q = 32'sd1 << FRAC;

   // Expected response word.
   typedef struct packed {
      lkv_pkg::word_type idx;
      logic [31:0]       e0;
      logic [31:0]       e1;
      logic [31:0]       e2;
      logic [31:0]       e3;
      logic              degen;
      logic              lst;
   } col_word_type;

   // One directed stimulus row; when has_exp is set, word 3 is typed in.
   typedef struct {
      logic [31:0]  px, py, pz, tx, ty, tz;
      bit           has_exp;
      col_word_type exp_w3;
   } cam_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_word_index;
   logic signed [31:0] rsp_elem0, rsp_elem1, rsp_elem2, rsp_elem3;
   logic rsp_degenerate, rsp_last;

   col_word_type matrix_q[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   look_at_view_matrix u_dut (.*);

   always #2 clock = ~clock;

   // Hard stop on a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[look_at_view_matrix] ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] mag64(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Fixed-point product truncated toward zero.
   function automatic longint fx_mul(input longint a, input longint b);
      logic [63:0] p;
      p = (mag64(a) * mag64(b)) >> FRAC;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   // Unit vector; returns 1 for a zero vector.
   function automatic bit unit_vec(input longint v[3], output longint o[3]);
      logic [63:0] m[3];
      logic [63:0] top, sum, len;
      top = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag64(v[i]);
         if (m[i] > top) top = m[i];
      end
      if (top == 0) begin
         for (int i = 0; i < 3; i++) o[i] = 0;
         return 1'b1;
      end
      while (top >= (64'd1 << 30)) begin
         top >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (top < (64'd1 << 29)) begin
         top <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'((m[i] << FRAC) / len);
         if (v[i] < 0) o[i] = -o[i];
      end
      return 1'b0;
   endfunction

   function automatic longint neg_dot(input longint a[3], input longint p[3]);
      return clamp32(-(fx_mul(a[0], p[0]) + fx_mul(a[1], p[1]) + fx_mul(a[2], p[2])));
   endfunction

   // Build the four expected matrix words for one camera transaction.
   task automatic predict_view_matrix(input logic signed [31:0] px, py, pz, tx, ty, tz);
      longint p[3], d[3], f[3], h[3], r[3], u[3];
      bit degen;
      col_word_type w;
      p[0] = px; p[1] = py; p[2] = pz;
      d[0] = p[0] - longint'(tx);
      d[1] = p[1] - longint'(ty);
      d[2] = p[2] - longint'(tz);
      degen = unit_vec(d, f);
      h[0] = f[2]; h[1] = 0; h[2] = -f[0];
      if (unit_vec(h, r)) degen = 1'b1;
      u[0] = fx_mul(f[1], r[2]) - fx_mul(f[2], r[1]);
      u[1] = fx_mul(f[2], r[0]) - fx_mul(f[0], r[2]);
      u[2] = fx_mul(f[0], r[1]) - fx_mul(f[1], r[0]);
      for (int k = 0; k < 3; k++) begin
         w.idx = lkv_pkg::word_type'(k);
         w.e0 = 32'(clamp32(r[k]));
         w.e1 = 32'(clamp32(u[k]));
         w.e2 = 32'(clamp32(f[k]));
         w.e3 = '0;
         w.degen = degen;
         w.lst = 1'b0;
         matrix_q.push_back(w);
      end
      w.idx = lkv_pkg::WORD_LAST;
      w.e0 = 32'(neg_dot(r, p));
      w.e1 = 32'(neg_dot(u, p));
      w.e2 = 32'(neg_dot(f, p));
      w.e3 = ONE_Q;
      w.degen = degen;
      w.lst = 1'b1;
      matrix_q.push_back(w);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got, exp);
      $display("mismatch %s: got %h expected %h", what, got, exp);
      errors++;
   endtask

   // Response checker, sampling at the rising edge.
   always @(posedge clock) begin
      col_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (matrix_q.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_word_index), 32'd0);
         end else begin
            e = matrix_q.pop_front();
            if (rsp_word_index !== e.idx)
               report_mismatch("word_index", 32'(rsp_word_index), 32'(e.idx));
            if (rsp_elem0 !== e.e0) report_mismatch("elem0", rsp_elem0, e.e0);
            if (rsp_elem1 !== e.e1) report_mismatch("elem1", rsp_elem1, e.e1);
            if (rsp_elem2 !== e.e2) report_mismatch("elem2", rsp_elem2, e.e2);
            if (rsp_elem3 !== e.e3) report_mismatch("elem3", rsp_elem3, e.e3);
            if (rsp_degenerate !== e.degen)
               report_mismatch("degenerate", 32'(rsp_degenerate), 32'(e.degen));
            if (rsp_last !== e.lst)
               report_mismatch("last", 32'(rsp_last), 32'(e.lst));
         end
      end
   end

   // Receiver back-pressure, changed at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Send one camera transaction; the matrix is predicted on acceptance.
   // Valid stays high into the next transaction unless the sender idles.
   task automatic send_camera(input logic [31:0] px, py, pz, tx, ty, tz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_target_x <= tx; req_target_y <= ty; req_target_z <= tz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_view_matrix(px, py, pz, tx, ty, tz);
      @(negedge clock);
   endtask

   // Random coordinate: mostly modest scene values, sometimes full range.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'sd1 << $urandom_range(30);
         2: return $urandom_range(3) == 0 ? 32'h80000000 : 32'h7fffffff;
         default: return 32'(int'($urandom_range(2000000)) - 1000000) <<< 6;
      endcase
   endfunction

   task automatic random_phase(input int n, input int idle, input int stall);
      logic [31:0] px, py, pz;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         px = rand_coord(); py = rand_coord(); pz = rand_coord();
         case ($urandom_range(15))
            // Position equals target.
            0: send_camera(px, py, pz, px, py, pz);
            // Looking straight along the y axis.
            1: send_camera(px, py, pz, px, rand_coord(), pz);
            default: send_camera(px, py, pz, rand_coord(), rand_coord(), rand_coord());
         endcase
      end
   endtask

   cam_row_type dir_rows[$];

   function automatic cam_row_type row(input logic [31:0] px, py, pz, tx, ty, tz,
                                       input bit has_exp = 0, input logic [31:0] e0 = 0,
                                       input logic [31:0] e1 = 0, input logic [31:0] e2 = 0,
                                       input logic dg = 0);
      cam_row_type c;
      c.px = px; c.py = py; c.pz = pz; c.tx = tx; c.ty = ty; c.tz = tz;
      c.has_exp = has_exp;
      c.exp_w3 = '{lkv_pkg::WORD_LAST, e0, e1, e2, ONE_Q, dg, 1'b1};
      return c;
   endfunction

   localparam logic [31:0] MAXV = 32'h7fffffff;
   localparam logic [31:0] MINV = 32'h80000000;

   initial begin
      col_word_type pred;
      // Directed table: known matrices typed in where obvious.
      dir_rows.push_back(row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
      dir_rows.push_back(row(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1, 0, 0, 0, 1));
      dir_rows.push_back(row(MINV, MINV, MINV, MINV, MINV, MINV, 1, 0, 0, 0, 1));
      // Along +z from origin toward -z: identity, no translation.
      dir_rows.push_back(row(0, 0, 0, 0, 0, MINV, 1, 0, 0, 0, 0));
      dir_rows.push_back(row(0, ONE_Q, 0, 0, 0, 0));
      dir_rows.push_back(row(0, MINV, 0, 0, MAXV, 0));
      dir_rows.push_back(row(MAXV, 0, MAXV, MINV, 0, MINV));
      dir_rows.push_back(row(MINV, MAXV, MINV, MAXV, MINV, MAXV));
      dir_rows.push_back(row(MAXV, MAXV, MAXV, 0, 0, 0));
      dir_rows.push_back(row(MINV, MINV, MINV, 0, 0, 0));
      dir_rows.push_back(row(ONE_Q, 0, 0, 0, 0, 0));
      dir_rows.push_back(row(0, 0, 1, 0, 0, 0));
      dir_rows.push_back(row(1, 1, 1, 0, 0, 0));
      dir_rows.push_back(row(32'hffffffff, 32'h55555555, 32'haaaaaaaa,
                             32'h5a5a5a5a, 32'ha5a5a5a5, 32'h0f0f0f0f));
      dir_rows.push_back(row(MAXV, MINV, MAXV, 1, 1, 1));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: the predictor covers every row; typed rows checked too.
      foreach (dir_rows[i]) begin
         send_camera(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz,
                     dir_rows[i].tx, dir_rows[i].ty, dir_rows[i].tz);
         pred = matrix_q[matrix_q.size() - 1];
         if (dir_rows[i].has_exp) begin
            if (pred.e0 !== dir_rows[i].exp_w3.e0)
               report_mismatch("directed elem0", pred.e0, dir_rows[i].exp_w3.e0);
            if (pred.e1 !== dir_rows[i].exp_w3.e1)
               report_mismatch("directed elem1", pred.e1, dir_rows[i].exp_w3.e1);
            if (pred.e2 !== dir_rows[i].exp_w3.e2)
               report_mismatch("directed elem2", pred.e2, dir_rows[i].exp_w3.e2);
            if (pred.degen !== dir_rows[i].exp_w3.degen)
               report_mismatch("directed degenerate", 32'(pred.degen),
                               32'(dir_rows[i].exp_w3.degen));
         end
      end

      // Random phases with different sender idling and receiver stalls.
      random_phase(100, 0, 0);
      random_phase(90, 80, 0);
      // Hold off until the pipeline has drained.
      req_valid <= 1'b0;
      while (matrix_q.size() != 0) @(negedge clock);
      random_phase(90, 0, 80);
      random_phase(120, 35, 35);

      req_valid <= 1'b0;
      while (matrix_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("[look_at_view_matrix] OK");
      end else begin
         $display("[look_at_view_matrix] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
sv/lkv_pkg.sv
sv/lkv_norm.sv
sv/look_at_view_matrix.sv
tb/look_at_view_matrix_tb.sv
